@@ sv/wprw_pkg.sv @@
// Shared command, status and state codes for the rwlock table.
`default_nettype none
package wprw_pkg;

    typedef enum logic [3:0] {
        CMD_CREATE       = 4'd0,
        CMD_CLOSE        = 4'd1,
        CMD_TRY_READ     = 4'd2,
        CMD_TRY_WRITE    = 4'd3,
        CMD_READ_BEGIN   = 4'd4,
        CMD_WRITE_BEGIN  = 4'd5,
        CMD_POLL_READ    = 4'd6,
        CMD_POLL_WRITE   = 4'd7,
        CMD_CANCEL       = 4'd8,
        CMD_READ_UNLOCK  = 4'd9,
        CMD_WRITE_UNLOCK = 4'd10,
        CMD_RESET_ALL    = 4'd11
    } cmd_t;

    typedef enum logic [3:0] {
        ST_OK            = 4'd0,
        ST_INVAL         = 4'd1,
        ST_STALE         = 4'd2,
        ST_EXHAUSTED     = 4'd3,
        ST_WOULD_BLOCK   = 4'd4,
        ST_PENDING       = 4'd5,
        ST_DISCONNECTED  = 4'd6,
        ST_INVALID_STATE = 4'd7,
        ST_CANCELLED     = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CLR_RD,
        S_CLR_WR
    } fsm_t;

    localparam logic [15:0] READERS_MAX = 16'hFFFF;

    // advance a generation, skipping zero
    function automatic logic [15:0] gen_next(input logic [15:0] g);
        logic [15:0] n;
        n = g + 16'd1;
        return (n == 16'd0) ? 16'd1 : n;
    endfunction

endpackage
`default_nettype wire

@@ sv/wprw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wprw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ sv/writer_preferring_rwlock_table_core.sv @@
// Each command reads its table word on accept, then modifies/writes it and loads the result beat.
// Commands do not overlap: req_stall holds the next one off until the current one has executed.
// reset_all sweeps every lock below the high mark, a read state then a write state per lock.
// The result sits in an output register, so it may wait while the block idles.
// Reset: asynchronous, active low; clears live flags, entry valid bits, the high
// mark and the control state. Entries not yet written read as all zero.
`default_nettype none
module writer_preferring_rwlock_table_core #(
    parameter int LOCK_COUNT   = 16,
    parameter int WAITER_SLOTS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [3:0]  command,
    input  wire logic [7:0]  lock_index,
    input  wire logic [15:0] lock_tag,
    input  wire logic [7:0]  waiter_index,
    input  wire logic        cancel_requested,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic [3:0]       status,
    output logic [7:0]       out_lock_index,
    output logic [15:0]      out_tag,
    output logic [7:0]       out_waiter_index,
    output logic [15:0]      reader_count,
    output logic             is_write_locked
);
    import wprw_pkg::*;

    localparam int IW = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
    localparam int MW = $clog2(LOCK_COUNT + 1);
    localparam int W  = WAITER_SLOTS;
    localparam int WW = (W > 1) ? $clog2(W) : 1;
    localparam int CW = $clog2(W + 1);

    // One table word per lock; the live flag stays in flops for the create search.
    typedef struct packed {
        logic [15:0]   gen;
        logic [15:0]   readers;
        logic          wholds;
        logic [CW-1:0] wwait;
        logic [W-1:0]  act;
        logic [W-1:0]  gnt;
        logic [W-1:0]  wr;
    } ent_t;

    localparam int EW = $bits(ent_t);

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic [CW-1:0] pop(input logic [W-1:0] v);
        logic [CW-1:0] c;
        c = '0;
        for (int k = 0; k < W; k++)
        begin
            c = c + CW'(v[k]);
        end
        return c;
    endfunction

    function automatic ent_t dec_writers(input ent_t x);
        ent_t y;
        y = x;
        if (x.wwait != '0)
        begin
            y.wwait = x.wwait - CW'(1);
        end
        return y;
    endfunction

    // Hand the lock to the first ungranted writer, else to waiting readers
    // while the reader count has room.
    function automatic ent_t wake(input ent_t x);
        ent_t          y;
        logic [W-1:0]  wel;
        logic [W-1:0]  rel;
        logic [W-1:0]  g;
        logic [WW-1:0] pick;
        logic          found;
        logic [16:0]   room;
        logic [CW-1:0] cnt;
        y     = x;
        wel   = x.act & ~x.gnt & x.wr;
        rel   = x.act & ~x.gnt & ~x.wr;
        g     = '0;
        pick  = '0;
        found = 1'b0;
        cnt   = '0;
        room  = 17'(READERS_MAX) - 17'(x.readers);
        if (x.wwait != '0)
        begin
            for (int k = W - 1; k >= 0; k--)
            begin
                if (wel[k])
                begin
                    pick  = WW'(k);
                    found = 1'b1;
                end
            end
        end
        if (found)
        begin
            y.gnt[pick] = 1'b1;
            y.wholds    = 1'b1;
        end
        else
        begin
            for (int k = 0; k < W; k++)
            begin
                if (rel[k])
                begin
                    if (17'(cnt) < room)
                    begin
                        g[k] = 1'b1;
                    end
                    cnt = cnt + CW'(1);
                end
            end
            y.gnt     = x.gnt | g;
            y.readers = x.readers + 16'(pop(g));
        end
        return y;
    endfunction

    // Drop a waiter and return whatever grant it held.
    function automatic ent_t drop_waiter(input ent_t x, input logic [W-1:0] b);
        ent_t y;
        y = x;
        if ((x.gnt & b) != '0)
        begin
            if ((x.wr & b) != '0)
            begin
                y.wholds = 1'b0;
            end
            else if (x.readers != 16'd0)
            begin
                y.readers = x.readers - 16'd1;
            end
        end
        if ((x.wr & b) != '0)
        begin
            y = dec_writers(y);
        end
        y.act = y.act & ~b;
        y.gnt = y.gnt & ~b;
        return y;
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    fsm_t                  state_reg, state_next;
    logic [3:0]            cmd_reg;
    logic [7:0]            idx_reg;
    logic [15:0]           tag_reg;
    logic [7:0]            wix_reg;
    logic                  cancel_reg;
    logic [IW-1:0]         addr_reg;
    logic                  rng_reg;
    logic                  free_ok_reg;
    logic                  ent_ok_reg;
    logic [IW-1:0]         ptr_reg;
    logic [MW-1:0]         mark_reg;
    logic [LOCK_COUNT-1:0] live_reg;
    logic [LOCK_COUNT-1:0] vld_reg;

    logic                  rsp_valid_reg;
    logic [3:0]            status_reg;
    logic [7:0]            oidx_reg;
    logic [15:0]           otag_reg;
    logic [7:0]            owait_reg;
    logic [15:0]           rcnt_reg;
    logic                  wl_reg;

    // ------------------------------------------------------------------
    // Accept side: pick the table word to read
    // ------------------------------------------------------------------
    logic          acc;
    logic          free_ok;
    logic [IW-1:0] free_idx;
    logic          in_rng;
    logic [IW-1:0] acc_addr;

    always_comb
    begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int k = LOCK_COUNT - 1; k >= 0; k--)
        begin
            if (!live_reg[k])
            begin
                free_ok  = 1'b1;
                free_idx = IW'(k);
            end
        end
    end

    assign acc    = req_valid && (state_reg == S_IDLE);
    assign in_rng = ({1'b0, lock_index} < 9'(LOCK_COUNT));

    always_comb
    begin
        if ((command == CMD_CREATE) && free_ok)
        begin
            acc_addr = free_idx;
        end
        else if (in_rng)
        begin
            acc_addr = lock_index[IW-1:0];
        end
        else
        begin
            acc_addr = '0;
        end
    end

    // ------------------------------------------------------------------
    // Table memory
    // ------------------------------------------------------------------
    logic          mem_rd_en;
    logic [IW-1:0] mem_rd_addr;
    logic [EW-1:0] mem_rd_data;
    logic          mem_wr_en;
    logic [IW-1:0] mem_wr_addr;
    logic [EW-1:0] mem_wr_data;

    assign mem_rd_en   = acc || (state_reg == S_CLR_RD);
    assign mem_rd_addr = acc ? acc_addr : ptr_reg;

    wprw_ram #(
        .WIDTH (EW),
        .DEPTH (LOCK_COUNT)
    ) u_table (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // ------------------------------------------------------------------
    // Execute: modify the word read on accept
    // ------------------------------------------------------------------
    ent_t          e;
    ent_t          n;
    ent_t          sweep_ent;
    logic          hit;
    logic          wix_ok;
    logic [W-1:0]  b;
    logic          slot_ok;
    logic [WW-1:0] slot;
    logic          go;
    logic          x_wen;
    logic          x_live_set;
    logic          x_live_clr;
    logic          x_mark_clr;
    logic          x_mark_upd;
    logic          vis;
    status_t       st;
    logic [7:0]    oidx;
    logic [15:0]   otag;
    logic [7:0]    owait;

    assign e      = ent_ok_reg ? ent_t'(mem_rd_data) : '0;
    assign hit    = rng_reg && live_reg[addr_reg] && (e.gen == tag_reg);
    assign wix_ok = ({1'b0, wix_reg} < 9'(W));
    assign b      = wix_ok ? (W'(1) << wix_reg[WW-1:0]) : '0;
    assign go     = (state_reg == S_EXEC) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        slot_ok = 1'b0;
        slot    = '0;
        for (int k = W - 1; k >= 0; k--)
        begin
            if (!e.act[k])
            begin
                slot_ok = 1'b1;
                slot    = WW'(k);
            end
        end
    end

    always_comb
    begin
        n          = e;
        x_wen      = 1'b0;
        x_live_set = 1'b0;
        x_live_clr = 1'b0;
        x_mark_clr = 1'b0;
        x_mark_upd = 1'b0;
        vis        = hit;
        st         = ST_INVAL;
        oidx       = 8'd0;
        otag       = 16'd0;
        owait      = 8'd0;
        unique case (cmd_reg)
            CMD_CREATE:
            begin
                if (free_ok_reg)
                begin
                    n          = '0;
                    n.gen      = gen_next(e.gen);
                    x_wen      = 1'b1;
                    x_live_set = 1'b1;
                    x_mark_upd = 1'b1;
                    vis        = 1'b1;
                    oidx       = 8'(addr_reg);
                    otag       = n.gen;
                    st         = ST_OK;
                end
                else
                begin
                    st = ST_EXHAUSTED;
                end
            end
            CMD_CLOSE:
            begin
                if (!hit)
                begin
                    st = ST_STALE;
                end
                else
                begin
                    n.act      = '0;
                    n.wwait    = '0;
                    x_wen      = 1'b1;
                    x_live_clr = 1'b1;
                    vis        = 1'b0;
                    st         = ST_OK;
                end
            end
            CMD_TRY_READ:
            begin
                if (!hit)
                begin
                    st = ST_STALE;
                end
                else if (e.wholds || (e.wwait != '0) || (e.readers == READERS_MAX))
                begin
                    st = ST_WOULD_BLOCK;
                end
                else
                begin
                    n.readers = e.readers + 16'd1;
                    x_wen     = 1'b1;
                    oidx      = idx_reg;
                    otag      = tag_reg;
                    st        = ST_OK;
                end
            end
            CMD_TRY_WRITE:
            begin
                if (!hit)
                begin
                    st = ST_STALE;
                end
                else if (e.wholds || (e.readers != 16'd0))
                begin
                    st = ST_WOULD_BLOCK;
                end
                else
                begin
                    n.wholds = 1'b1;
                    x_wen    = 1'b1;
                    oidx     = idx_reg;
                    otag     = tag_reg;
                    st       = ST_OK;
                end
            end
            CMD_READ_BEGIN, CMD_WRITE_BEGIN:
            begin
                if (!hit)
                begin
                    st = ST_STALE;
                end
                else if (!slot_ok)
                begin
                    st = ST_EXHAUSTED;
                end
                else
                begin
                    n.act[slot] = 1'b1;
                    n.gnt[slot] = 1'b0;
                    n.wr[slot]  = (cmd_reg == CMD_WRITE_BEGIN);
                    if (cmd_reg == CMD_WRITE_BEGIN)
                    begin
                        n.wwait = e.wwait + CW'(1);
                    end
                    x_wen = 1'b1;
                    oidx  = idx_reg;
                    otag  = tag_reg;
                    owait = 8'(slot);
                    st    = ST_OK;
                end
            end
            CMD_POLL_READ, CMD_POLL_WRITE:
            begin
                if (!hit)
                begin
                    st = ST_DISCONNECTED;
                end
                else if (!wix_ok)
                begin
                    st = ST_INVAL;
                end
                else if (((e.act & b) == '0)
                         || (((e.wr & b) != '0) != (cmd_reg == CMD_POLL_WRITE)))
                begin
                    st = ST_INVALID_STATE;
                end
                else if (cancel_reg)
                begin
                    n     = drop_waiter(e, b);
                    x_wen = 1'b1;
                    st    = ST_CANCELLED;
                end
                else if ((e.gnt & b) != '0)
                begin
                    n.act = e.act & ~b;
                    n.gnt = e.gnt & ~b;
                    if (cmd_reg == CMD_POLL_WRITE)
                    begin
                        n = dec_writers(n);
                    end
                    x_wen = 1'b1;
                    oidx  = idx_reg;
                    otag  = tag_reg;
                    st    = ST_OK;
                end
                else if (cmd_reg == CMD_POLL_READ)
                begin
                    if (e.wholds || (e.wwait != '0))
                    begin
                        st = ST_PENDING;
                    end
                    else if (e.readers == READERS_MAX)
                    begin
                        st = ST_WOULD_BLOCK;
                    end
                    else
                    begin
                        n.readers = e.readers + 16'd1;
                        n.act     = e.act & ~b;
                        x_wen     = 1'b1;
                        oidx      = idx_reg;
                        otag      = tag_reg;
                        st        = ST_OK;
                    end
                end
                else
                begin
                    if (e.wholds || (e.readers != 16'd0))
                    begin
                        st = ST_PENDING;
                    end
                    else
                    begin
                        n.wholds = 1'b1;
                        n        = dec_writers(n);
                        n.act    = e.act & ~b;
                        x_wen    = 1'b1;
                        oidx     = idx_reg;
                        otag     = tag_reg;
                        st       = ST_OK;
                    end
                end
            end
            CMD_CANCEL:
            begin
                st = ST_OK;
                if (hit)
                begin
                    if (!wix_ok)
                    begin
                        st = ST_INVAL;
                    end
                    else if ((e.act & b) != '0)
                    begin
                        n     = drop_waiter(e, b);
                        x_wen = 1'b1;
                    end
                end
            end
            CMD_READ_UNLOCK:
            begin
                if (!hit)
                begin
                    st = ST_STALE;
                end
                else if (e.readers == 16'd0)
                begin
                    st = ST_INVALID_STATE;
                end
                else
                begin
                    n.readers = e.readers - 16'd1;
                    if (n.readers == 16'd0)
                    begin
                        n = wake(n);
                    end
                    x_wen = 1'b1;
                    st    = ST_OK;
                end
            end
            CMD_WRITE_UNLOCK:
            begin
                if (!hit)
                begin
                    st = ST_STALE;
                end
                else if (!e.wholds)
                begin
                    st = ST_INVALID_STATE;
                end
                else
                begin
                    n.wholds = 1'b0;
                    n        = wake(n);
                    x_wen    = 1'b1;
                    st       = ST_OK;
                end
            end
            CMD_RESET_ALL:
            begin
                x_mark_clr = 1'b1;
                vis        = 1'b0;
                st         = ST_OK;
            end
            default:
            begin
                st = ST_INVAL;
            end
        endcase
    end

    // Sweep word: new generation, everything else cleared.
    always_comb
    begin
        sweep_ent     = '0;
        sweep_ent.gen = gen_next(e.gen);
    end

    assign mem_wr_en   = (go && x_wen) || (state_reg == S_CLR_WR);
    assign mem_wr_addr = (state_reg == S_CLR_WR) ? ptr_reg : addr_reg;
    assign mem_wr_data = (state_reg == S_CLR_WR) ? EW'(sweep_ent) : EW'(n);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic sweep_last;

    assign sweep_last = ((9'(ptr_reg) + 9'd1) == 9'(mark_reg));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if ((command == CMD_RESET_ALL) && (mark_reg != '0))
                    begin
                        state_next = S_CLR_RD;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                if (go)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CLR_RD:
            begin
                state_next = S_CLR_WR;
            end
            S_CLR_WR:
            begin
                state_next = sweep_last ? S_EXEC : S_CLR_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != S_IDLE);

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mark_reg      <= '0;
            live_reg      <= '0;
            vld_reg       <= '0;
            ptr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (acc)
            begin
                ptr_reg <= '0;
            end
            else if ((state_reg == S_CLR_WR) && !sweep_last)
            begin
                ptr_reg <= ptr_reg + IW'(1);
            end
            // drop the live flag of each swept lock
            if (state_reg == S_CLR_WR)
            begin
                live_reg[ptr_reg] <= 1'b0;
            end
            if (mem_wr_en)
            begin
                vld_reg[mem_wr_addr] <= 1'b1;
            end
            if (go)
            begin
                if (x_live_set)
                begin
                    live_reg[addr_reg] <= 1'b1;
                end
                if (x_live_clr)
                begin
                    live_reg[addr_reg] <= 1'b0;
                end
                if (x_mark_clr)
                begin
                    mark_reg <= '0;
                end
                else if (x_mark_upd && (9'(addr_reg) >= 9'(mark_reg)))
                begin
                    mark_reg <= MW'(9'(addr_reg) + 9'd1);
                end
            end
            // hold the beat until taken, load the next one when free
            if (go)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            cmd_reg     <= command;
            idx_reg     <= lock_index;
            tag_reg     <= lock_tag;
            wix_reg     <= waiter_index;
            cancel_reg  <= cancel_requested;
            addr_reg    <= acc_addr;
            rng_reg     <= in_rng;
            free_ok_reg <= free_ok;
        end
        if (mem_rd_en)
        begin
            ent_ok_reg <= vld_reg[mem_rd_addr];
        end
        if (go)
        begin
            status_reg <= 4'(st);
            oidx_reg   <= oidx;
            otag_reg   <= otag;
            owait_reg  <= owait;
            rcnt_reg   <= vis ? n.readers : 16'd0;
            wl_reg     <= vis ? n.wholds : 1'b0;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign status           = status_reg;
    assign out_lock_index   = oidx_reg;
    assign out_tag          = otag_reg;
    assign out_waiter_index = owait_reg;
    assign reader_count     = rcnt_reg;
    assign is_write_locked  = wl_reg;

endmodule
`default_nettype wire

@@ sv/wprw_checker.sv @@
// Port-level checks for the rwlock table core, bound to the core module.
`default_nettype none
module wprw_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_stall,
    input wire logic        rsp_valid,
    input wire logic        rsp_stall,
    input wire logic [3:0]  status,
    input wire logic [7:0]  out_waiter_index,
    input wire logic [15:0] reader_count,
    input wire logic        is_write_locked
);
    import wprw_pkg::*;

    // a stalled result beat stays up
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result beat dropped while stalled");

    // one command at a time: busy right after an accepted beat
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second command accepted back to back");

    // a failed lookup shows no lock state
    a_stale_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_STALE || status == ST_DISCONNECTED)
        |-> reader_count == 16'd0 && !is_write_locked)
        else $error("stale result carries lock state");

    // only a successful begin hands out a waiter slot
    a_slot_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && out_waiter_index != 8'd0 |-> status == ST_OK)
        else $error("waiter slot on a failed command");

endmodule

bind writer_preferring_rwlock_table_core wprw_checker u_wprw_checker (.*);
`default_nettype wire
